@@ rtl/core/mctt_pkg.sv @@
package mctt_pkg;

  localparam int unsigned IDX_W    = 4;
  localparam int unsigned TAG_OUT_W = 16;
  localparam int unsigned PERIOD_W = 32;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_STOP   = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_EVENT  = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // One result word as it leaves the block
  typedef struct packed {
    logic                 kind;
    logic                 status;
    logic [IDX_W-1:0]     fired_index;
    logic                 deferred;
    logic [TAG_OUT_W-1:0] tag_out;
    logic                 last;
  } result_t;

endpackage

@@ rtl/core/mctt_mem.sv @@
module mctt_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 82,
  parameter int unsigned AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/mctt_out_reg.sv @@
module mctt_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mctt_pkg::result_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mctt_pkg::result_t res_o
);
  import mctt_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= push_i;
    end
  end

  // payload holds while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (free_o && push_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

@@ rtl/core/multi_channel_tick_timer.sv @@
// Bank of NUM_TIMERS countdown timers, one-shot or periodic.
// Input channel (in_valid_i / in_stall_o): one word per operation, op_i selects
// create, start, stop or a one-millisecond tick. A word is taken when valid is
// high and stall is low; stall stays high while an operation is in progress.
// Output channel (out_valid_o / out_stall_i): create, start and stop each
// return one status word with last_o set. A tick returns one expiry word per
// timer that reaches zero, in ascending timer index, last_o on the final one;
// a tick with no expiry returns nothing.
// Sequence: a command is accepted, then does one read-modify-write of the
// timer memory. A tick walks the single read port of the timer memory one
// entry per cycle while the output can take its words, and one expiry is held
// back so that the final word can be marked. Output stalls can hold either.
// A result sits in an output register, so a stalled receiver holds the
// sequencer only when a further word has to be placed.
// Reset clears the created and running flags at once; entries of a timer
// never created read as zero, so no clearing pass is needed.
module multi_channel_tick_timer #(
  parameter int unsigned NUM_TIMERS = 16,
  parameter int unsigned TAG_WIDTH  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [3:0]  timer_index_i,
  input  logic        one_shot_i,
  input  logic        urgent_i,
  input  logic [31:0] period_ms_i,
  input  logic        tag_given_i,
  input  logic [15:0] tag_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic        status_o,
  output logic [3:0]  fired_index_o,
  output logic        deferred_o,
  output logic [15:0] tag_out_o,
  output logic        last_o
);
  import mctt_pkg::*;

  localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CW = $clog2(NUM_TIMERS + 1);

  typedef struct packed {
    logic                 one_shot;
    logic                 urgent;
    logic [PERIOD_W-1:0]  remaining;
    logic [PERIOD_W-1:0]  reload;
    logic [TAG_WIDTH-1:0] tag;
  } entry_t;

  localparam int unsigned EW = $bits(entry_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMD,
    S_SCAN,
    S_FLUSH
  } state_e;

  state_e                state_q;
  logic [CW-1:0]         scan_q;
  logic                  pend_valid_q;
  result_t               pend_q;
  logic [NUM_TIMERS-1:0] created_q;
  logic [NUM_TIMERS-1:0] running_q;

  logic [1:0]            op_q;
  logic [IDX_W-1:0]      idx_q;
  logic                  one_shot_q;
  logic                  urgent_q;
  logic [PERIOD_W-1:0]   period_q;
  logic                  tag_given_q;
  logic [TAG_OUT_W-1:0]  tag_q;

  logic [IW-1:0] cmd_addr;
  logic [IW-1:0] scan_addr;
  logic [IW-1:0] cur_addr;
  logic [IW-1:0] rd_addr;
  logic [EW-1:0] rdata;
  entry_t        ent;
  entry_t        wr_ent;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;

  logic                idx_ok;
  logic                scan_last;
  logic                active;
  logic [PERIOD_W-1:0] dec;
  logic                fire;
  logic                can_adv;
  logic                out_free;
  logic                push;
  result_t             push_res;
  result_t             out_res;
  logic                cmd_status;

  assign in_stall_o = (state_q != S_IDLE);

  assign cmd_addr  = IW'(idx_q);
  assign scan_addr = scan_q[IW-1:0];
  assign cur_addr  = (state_q == S_SCAN) ? scan_addr : cmd_addr;
  assign idx_ok    = (32'(idx_q) < 32'(NUM_TIMERS));
  assign scan_last = (scan_q == CW'(NUM_TIMERS - 1));

  // an entry never created reads as its reset value
  assign ent = created_q[cur_addr] ? entry_t'(rdata) : '0;

  assign active  = running_q[scan_addr] && (ent.remaining != '0);
  assign dec     = ent.remaining - PERIOD_W'(1);
  assign fire    = active && (dec == '0);
  assign can_adv = !fire || !pend_valid_q || out_free;

  always_comb begin
    unique case (state_q)
      S_IDLE: begin
        rd_addr = (op_i == OP_TICK) ? '0 : IW'(timer_index_i);
      end
      S_SCAN: begin
        if (!can_adv) begin
          rd_addr = scan_addr;
        end else if (scan_last) begin
          rd_addr = '0;
        end else begin
          rd_addr = IW'(scan_q + CW'(1));
        end
      end
      default: begin
        rd_addr = cmd_addr;
      end
    endcase
  end

  always_comb begin
    cmd_status = STATUS_OK;
    if (!idx_ok) begin
      cmd_status = STATUS_ERR;
    end else begin
      unique case (op_q)
        OP_CREATE: cmd_status = running_q[cmd_addr] ? STATUS_ERR : STATUS_OK;
        OP_START:  cmd_status = created_q[cmd_addr] ? STATUS_OK : STATUS_ERR;
        OP_STOP:   cmd_status = STATUS_OK;
        OP_TICK:   cmd_status = STATUS_OK;
      endcase
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cmd_addr;
    wr_ent    = ent;
    push      = 1'b0;
    push_res  = pend_q;
    unique case (state_q)
      S_IDLE: begin
      end
      S_CMD: begin
        push                 = out_free;
        push_res             = '0;
        push_res.kind        = KIND_STATUS;
        push_res.status      = cmd_status;
        push_res.last        = 1'b1;
        if (op_q == OP_CREATE) begin
          wr_ent.one_shot = one_shot_q;
          wr_ent.urgent   = urgent_q;
        end else begin
          wr_ent.remaining = period_q;
          wr_ent.reload    = period_q;
          if (tag_given_q) begin
            wr_ent.tag = TAG_WIDTH'(tag_q);
          end
        end
        mem_we = out_free && (cmd_status == STATUS_OK) &&
                 ((op_q == OP_CREATE) || (op_q == OP_START));
      end
      S_SCAN: begin
        mem_waddr        = scan_addr;
        mem_we           = active && can_adv;
        wr_ent.remaining = (fire && !ent.one_shot) ? ent.reload : dec;
        // a newer expiry pushes the held one out, not the final word
        push             = fire && pend_valid_q && can_adv;
        push_res.last    = 1'b0;
      end
      S_FLUSH: begin
        push          = pend_valid_q && out_free;
        push_res.last = 1'b1;
      end
    endcase
  end

  mctt_mem #(
    .DEPTH (NUM_TIMERS),
    .WIDTH (EW),
    .AW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (EW'(wr_ent)),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  mctt_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (push_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign kind_o        = out_res.kind;
  assign status_o      = out_res.status;
  assign fired_index_o = out_res.fired_index;
  assign deferred_o    = out_res.deferred;
  assign tag_out_o     = out_res.tag_out;
  assign last_o        = out_res.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      scan_q       <= '0;
      pend_valid_q <= 1'b0;
      created_q    <= '0;
      running_q    <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            scan_q  <= '0;
            state_q <= (op_i == OP_TICK) ? S_SCAN : S_CMD;
          end
        end
        S_CMD: begin
          if (out_free) begin
            state_q <= S_IDLE;
            if (cmd_status == STATUS_OK && idx_ok) begin
              unique case (op_q)
                OP_CREATE: created_q[cmd_addr] <= 1'b1;
                OP_START:  running_q[cmd_addr] <= 1'b1;
                OP_STOP:   running_q[cmd_addr] <= 1'b0;
                OP_TICK:   ;
              endcase
            end
          end
        end
        S_SCAN: begin
          if (can_adv) begin
            if (fire) begin
              pend_valid_q <= 1'b1;
              if (ent.one_shot) begin
                running_q[scan_addr] <= 1'b0;
              end
            end
            if (scan_last) begin
              state_q <= S_FLUSH;
            end else begin
              scan_q <= scan_q + CW'(1);
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid_q || out_free) begin
            pend_valid_q <= 1'b0;
            state_q      <= S_IDLE;
          end
        end
      endcase
    end
  end

  // input word and held expiry
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      op_q        <= op_i;
      idx_q       <= timer_index_i;
      one_shot_q  <= one_shot_i;
      urgent_q    <= urgent_i;
      period_q    <= period_ms_i;
      tag_given_q <= tag_given_i;
      tag_q       <= tag_in_i;
    end
    if (state_q == S_SCAN && can_adv && fire) begin
      pend_q.kind        <= KIND_EVENT;
      pend_q.status      <= STATUS_OK;
      pend_q.fired_index <= IDX_W'(scan_q);
      pend_q.deferred    <= !ent.urgent;
      pend_q.tag_out     <= TAG_OUT_W'(ent.tag);
      pend_q.last        <= 1'b0;
    end
  end

  a_running_created : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (running_q & ~created_q) == '0)
    else $error("timer running without having been created");

  a_pend_in_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (state_q == S_SCAN || state_q == S_FLUSH))
    else $error("held expiry outside a tick");

  a_flush_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH && pend_valid_q && out_free) |=>
      (out_valid_o && last_o && kind_o == KIND_EVENT))
    else $error("final expiry of a tick not marked last");

  a_cmd_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMD && out_free) |=>
      (state_q == S_IDLE && out_valid_o && last_o && kind_o == KIND_STATUS))
    else $error("command did not return a single status word");

endmodule
